@@ sv/pts_pkg.sv @@
// Shared types and constants of the profile table statistics core.
// No dependencies; imported by every module of the block.
`default_nettype none
package pts_pkg;

    localparam int MAX_ROWS = 256;
    localparam int ROW_W = 9;
    localparam int DIV_CNT_W = 6;
    localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(63);

    localparam logic [19:0] USEC_PER_S = 20'd1000000;
    localparam logic [9:0] PERMILLE = 10'd1000;

    localparam logic [ROW_W-1:0] ROW_CAP = ROW_W'(MAX_ROWS);
    localparam logic [ROW_W-1:0] ROW_LIMIT_RST = ROW_W'(256);

    typedef enum logic [1:0] {
        CFG_TIMER_FREQ   = 2'd0,
        CFG_BLOCK_PERIOD = 2'd1,
        CFG_ROW_LIMIT    = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_idx;

    // One classified entry on its way from the front end to the back end.
    typedef struct packed {
        logic [31:0]      tag;
        logic [31:0]      runs;
        logic [63:0]      sum;
        logic [63:0]      peak;
        logic [31:0]      overruns;
        logic             last;
        logic             valid;
        logic [ROW_W-1:0] rows;
    } t_job;

endpackage
`default_nettype wire

@@ sv/profile_table_statistics_core.sv @@
// Top level of the profile table statistics core: configuration registers,
// front end, entry queue and back end. Depends on pts_pkg and all pts_ modules.
//
// Entries go in through a push/full queue port and one result per entry comes
// out through an empty/pop port. The front end classifies an entry on the cycle
// it is pushed and stores it in a two-entry queue, so pushes continue while the
// back end works. In the back end a row entry makes four passes of the shared
// radix-2 divider (mean cycles, mean time, peak time, load) plus multiply, add
// and handoff steps, from leaving the queue until its result is waiting. A zero
// frequency or a zero period skips the divider passes it makes pointless. A
// skipped entry goes straight to the handoff state. The back end starts the next
// entry only once the result register has been popped. Configuration writes
// take effect at once and are meant to be made while no entry is in flight.
`default_nettype none
module profile_table_statistics_core import pts_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_cfg_we,
    input  wire logic [1:0]       i_cfg_idx,
    input  wire logic [31:0]      i_cfg_data,
    input  wire logic             push,
    output logic                  full,
    input  wire logic [31:0]      i_entry_tag,
    input  wire logic [31:0]      i_run_count,
    input  wire logic [63:0]      i_cycle_sum,
    input  wire logic [63:0]      i_cycle_peak,
    input  wire logic [31:0]      i_overrun_count,
    input  wire logic             i_end_of_table,
    output logic                  empty,
    input  wire logic             pop,
    output logic                  o_row_valid,
    output logic [31:0]           o_row_tag,
    output logic [31:0]           o_row_runs,
    output logic [31:0]           o_mean_us,
    output logic [31:0]           o_peak_us,
    output logic [31:0]           o_row_load,
    output logic [31:0]           o_row_overruns,
    output logic [31:0]           o_load_sum,
    output logic [9:0]            o_headroom_permille,
    output logic [ROW_W-1:0]      o_rows_so_far,
    output logic                  o_last_row
);

    logic [31:0]      r_freq;
    logic [31:0]      r_period;
    logic [ROW_W-1:0] r_row_limit;
    logic             w_accept;
    t_job             w_front_job;
    t_job             w_queue_job;
    logic             w_queue_empty;
    logic             w_take;

    assign w_accept = push && !full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq      <= '0;
            r_period    <= '0;
            r_row_limit <= ROW_LIMIT_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_TIMER_FREQ:   r_freq      <= i_cfg_data;
                CFG_BLOCK_PERIOD: r_period    <= i_cfg_data;
                CFG_ROW_LIMIT:    r_row_limit <= i_cfg_data[ROW_W-1:0];
                default:          r_freq      <= r_freq;
            endcase
        end
    end

    pts_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_accept),
        .i_row_limit     (r_row_limit),
        .i_entry_tag     (i_entry_tag),
        .i_run_count     (i_run_count),
        .i_cycle_sum     (i_cycle_sum),
        .i_cycle_peak    (i_cycle_peak),
        .i_overrun_count (i_overrun_count),
        .i_end_of_table  (i_end_of_table),
        .o_job           (w_front_job)
    );

    pts_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_accept),
        .i_job   (w_front_job),
        .i_rd    (w_take),
        .o_job   (w_queue_job),
        .o_full  (full),
        .o_empty (w_queue_empty)
    );

    pts_back u_back (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_job_ready         (!w_queue_empty),
        .i_job               (w_queue_job),
        .o_job_take          (w_take),
        .i_freq              (r_freq),
        .i_period            (r_period),
        .i_pop               (pop),
        .o_empty             (empty),
        .o_row_valid         (o_row_valid),
        .o_row_tag           (o_row_tag),
        .o_row_runs          (o_row_runs),
        .o_mean_us           (o_mean_us),
        .o_peak_us           (o_peak_us),
        .o_row_load          (o_row_load),
        .o_row_overruns      (o_row_overruns),
        .o_load_sum          (o_load_sum),
        .o_headroom_permille (o_headroom_permille),
        .o_rows_so_far       (o_rows_so_far),
        .o_last_row          (o_last_row)
    );

    // Headroom and total load must always agree in a waiting result.
    a_headroom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_load_sum >= 32'(PERMILLE)) ? (o_headroom_permille == '0)
                    : (32'(o_headroom_permille) + o_load_sum == 32'(PERMILLE))))
        else $error("headroom does not match total load");

    // A skipped entry carries no times and no load.
    a_skipped_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !o_row_valid) |-> (o_mean_us == '0 && o_peak_us == '0
                                       && o_row_load == '0 && o_row_tag == '0))
        else $error("skipped entry carries nonzero fields");

    // The row count never passes the hard table limit.
    a_rows_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_rows_so_far <= ROW_CAP))
        else $error("row count above limit");

endmodule
`default_nettype wire

@@ sv/pts_front.sv @@
// Front end: classifies each accepted entry and keeps the table's row count.
// Depends on pts_pkg.
`default_nettype none
module pts_front import pts_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_accept,
    input  wire logic [ROW_W-1:0] i_row_limit,
    input  wire logic [31:0]      i_entry_tag,
    input  wire logic [31:0]      i_run_count,
    input  wire logic [63:0]      i_cycle_sum,
    input  wire logic [63:0]      i_cycle_peak,
    input  wire logic [31:0]      i_overrun_count,
    input  wire logic             i_end_of_table,
    output t_job                  o_job
);

    logic [ROW_W-1:0] r_rows;
    logic [ROW_W-1:0] n_rows;
    logic [ROW_W-1:0] w_cap;
    logic             w_valid;
    logic [ROW_W-1:0] w_rows;

    assign w_cap   = (i_row_limit < ROW_CAP) ? i_row_limit : ROW_CAP;
    assign w_valid = (i_run_count != 32'd0) && (r_rows < w_cap);
    assign w_rows  = w_valid ? r_rows + ROW_W'(1) : r_rows;

    always_comb begin
        o_job.tag      = i_entry_tag;
        o_job.runs     = i_run_count;
        o_job.sum      = i_cycle_sum;
        o_job.peak     = i_cycle_peak;
        o_job.overruns = i_overrun_count;
        o_job.last     = i_end_of_table;
        o_job.valid    = w_valid;
        o_job.rows     = w_rows;
    end

    always_comb begin
        n_rows = r_rows;
        if (i_accept) begin
            n_rows = i_end_of_table ? '0 : w_rows;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= '0;
        end else begin
            r_rows <= n_rows;
        end
    end

endmodule
`default_nettype wire

@@ sv/pts_queue.sv @@
// Two-entry queue of classified entries between the front and back ends.
// Depends on pts_pkg.
`default_nettype none
module pts_queue import pts_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_wr,
    input  t_job      i_job,
    input  wire logic i_rd,
    output t_job      o_job,
    output logic      o_full,
    output logic      o_empty
);

    t_job       r_slot [2];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_job   = r_slot[r_rd_ptr];
    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_rd) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_count <= r_count + {1'b0, i_wr} - {1'b0, i_rd};
        end
    end

endmodule
`default_nettype wire

@@ sv/pts_div.sv @@
// Radix-2 restoring divider: 64-bit dividend by 32-bit divisor, one bit per cycle.
// Depends on pts_pkg.
`default_nettype none
module pts_div import pts_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [63:0] i_dividend,
    input  wire logic [31:0] i_divisor,
    output logic             o_done,
    output logic [63:0]      o_quotient
);

    logic [63:0]          r_q;
    logic [31:0]          r_rem;
    logic [31:0]          r_div;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;
    logic [32:0]          w_shift;
    logic [32:0]          w_diff;
    logic                 w_ge;

    assign w_shift    = {r_rem, r_q[63]};
    assign w_ge       = w_shift >= {1'b0, r_div};
    assign w_diff     = w_shift - {1'b0, r_div};
    assign o_done     = r_done;
    assign o_quotient = r_q;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[62:0], w_ge};
            r_rem <= w_ge ? w_diff[31:0] : w_shift[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + DIV_CNT_W'(1);
                if (r_cnt == DIV_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

endmodule
`default_nettype wire

@@ sv/pts_back.sv @@
// Back end: sequences the divisions and multiplications of one entry, keeps the
// table's load total and holds the finished result. Depends on pts_pkg, pts_div.
`default_nettype none
module pts_back import pts_pkg::*; (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_job_ready,
    input  t_job                  i_job,
    output logic                  o_job_take,
    input  wire logic [31:0]      i_freq,
    input  wire logic [31:0]      i_period,
    input  wire logic             i_pop,
    output logic                  o_empty,
    output logic                  o_row_valid,
    output logic [31:0]           o_row_tag,
    output logic [31:0]           o_row_runs,
    output logic [31:0]           o_mean_us,
    output logic [31:0]           o_peak_us,
    output logic [31:0]           o_row_load,
    output logic [31:0]           o_row_overruns,
    output logic [31:0]           o_load_sum,
    output logic [9:0]            o_headroom_permille,
    output logic [ROW_W-1:0]      o_rows_so_far,
    output logic                  o_last_row
);

    typedef enum logic [8:0] {
        S_IDLE     = 9'b000000001,
        S_MEAN_DIV = 9'b000000010,
        S_MUL_LO   = 9'b000000100,
        S_MUL_HI   = 9'b000001000,
        S_ADD      = 9'b000010000,
        S_US_DIV   = 9'b000100000,
        S_LOAD_MUL = 9'b001000000,
        S_LOAD_DIV = 9'b010000000,
        S_DONE     = 9'b100000000
    } t_state;

    t_state      r_state;
    t_job        r_job;
    logic [63:0] r_x;
    logic [51:0] r_plo;
    logic [31:0] r_phi;
    logic        r_conv_peak;
    logic [31:0] r_mean;
    logic [31:0] r_peak;
    logic [31:0] r_load;
    logic [31:0] r_acc;
    logic        r_out_full;

    logic        w_div_start;
    logic [63:0] w_div_dividend;
    logic [31:0] w_div_divisor;
    logic        w_div_done;
    logic [63:0] w_div_q;
    logic [51:0] w_mul_lo;
    logic [51:0] w_mul_hi;
    logic [41:0] w_mul_load;
    logic [63:0] w_half;
    logic [31:0] w_acc_next;

    assign o_job_take = (r_state == S_IDLE) && i_job_ready && !r_out_full;
    assign o_empty    = !r_out_full;

    assign w_mul_lo   = r_x[31:0] * USEC_PER_S;
    assign w_mul_hi   = r_x[63:32] * USEC_PER_S;
    assign w_mul_load = r_mean * PERMILLE;
    assign w_half     = {33'd0, i_freq[31:1]};
    assign w_acc_next = r_job.valid ? r_acc + r_load : r_acc;

    always_comb begin
        w_div_start    = 1'b0;
        w_div_dividend = i_job.sum;
        w_div_divisor  = i_job.runs;
        unique case (r_state)
            S_IDLE: begin
                w_div_start = o_job_take && i_job.valid;
            end
            S_ADD: begin
                w_div_start    = (i_freq != 32'd0);
                w_div_dividend = 64'(r_plo) + {r_phi, 32'd0} + w_half;
                w_div_divisor  = i_freq;
            end
            S_LOAD_MUL: begin
                w_div_start    = (i_period != 32'd0);
                w_div_dividend = 64'(w_mul_load);
                w_div_divisor  = i_period;
            end
            default: begin
                w_div_start = 1'b0;
            end
        endcase
    end

    pts_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quotient (w_div_q)
    );

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            S_IDLE: begin
                r_job  <= i_job;
                r_mean <= '0;
                r_peak <= '0;
                r_load <= '0;
                r_conv_peak <= 1'b0;
            end
            S_MEAN_DIV: begin
                r_x <= w_div_q;
            end
            S_MUL_LO: begin
                r_plo <= w_mul_lo;
            end
            S_MUL_HI: begin
                r_phi <= w_mul_hi[31:0];
            end
            S_ADD: begin
                // A zero frequency turns the time into zero without dividing.
                if (i_freq == 32'd0 && r_conv_peak) begin
                    r_peak <= '0;
                end else if (i_freq == 32'd0) begin
                    r_mean      <= '0;
                    r_x         <= r_job.peak;
                    r_conv_peak <= 1'b1;
                end
            end
            S_US_DIV: begin
                if (w_div_done && r_conv_peak) begin
                    r_peak <= w_div_q[31:0];
                end else if (w_div_done) begin
                    r_mean      <= w_div_q[31:0];
                    r_x         <= r_job.peak;
                    r_conv_peak <= 1'b1;
                end
            end
            S_LOAD_MUL: begin
                r_load <= '0;
            end
            S_LOAD_DIV: begin
                if (w_div_done) begin
                    r_load <= w_div_q[31:0];
                end
            end
            S_DONE: begin
                o_row_valid         <= r_job.valid;
                o_row_tag           <= r_job.valid ? r_job.tag : '0;
                o_row_runs          <= r_job.valid ? r_job.runs : '0;
                o_row_overruns      <= r_job.valid ? r_job.overruns : '0;
                o_mean_us           <= r_mean;
                o_peak_us           <= r_peak;
                o_row_load          <= r_load;
                o_load_sum          <= w_acc_next;
                o_headroom_permille <= (w_acc_next >= 32'(PERMILLE)) ? '0
                                       : PERMILLE - w_acc_next[9:0];
                o_rows_so_far       <= r_job.rows;
                o_last_row          <= r_job.last;
            end
            default: begin
                r_x <= r_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_acc      <= '0;
            r_out_full <= 1'b0;
        end else begin
            if (i_pop && r_out_full) begin
                r_out_full <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (o_job_take) begin
                        r_state <= i_job.valid ? S_MEAN_DIV : S_DONE;
                    end
                end
                S_MEAN_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_MUL_LO;
                    end
                end
                S_MUL_LO: r_state <= S_MUL_HI;
                S_MUL_HI: r_state <= S_ADD;
                S_ADD: begin
                    if (i_freq != 32'd0) begin
                        r_state <= S_US_DIV;
                    end else begin
                        r_state <= r_conv_peak ? S_LOAD_MUL : S_MUL_LO;
                    end
                end
                S_US_DIV: begin
                    if (w_div_done) begin
                        r_state <= r_conv_peak ? S_LOAD_MUL : S_MUL_LO;
                    end
                end
                S_LOAD_MUL: begin
                    r_state <= (i_period != 32'd0) ? S_LOAD_DIV : S_DONE;
                end
                S_LOAD_DIV: begin
                    if (w_div_done) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    r_acc      <= r_job.last ? '0 : w_acc_next;
                    r_out_full <= 1'b1;
                    r_state    <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire
